FILE: rtl/crv_pkg.sv
// crv_pkg: shared types and constants for the CSV row validator.
// Holds the result beat type, register indexes, field classes and byte codes.
// No dependencies.
package crv_pkg;

    // Configuration port
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_SEPARATOR  = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_QUOTE      = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_NEWLINE    = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CHECK_EN   = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TYPE_INDEX = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WANTED     = 3'd5;

    // Register reset values
    localparam logic [7:0]  SEPARATOR_RST  = 8'h2c;
    localparam logic [7:0]  QUOTE_RST      = 8'h22;
    localparam logic [7:0]  NEWLINE_RST    = 8'h0a;
    localparam logic [3:0]  CHECK_EN_RST   = 4'hf;
    localparam logic [15:0] TYPE_INDEX_RST = 16'd0;

    // Field classes
    typedef enum logic [1:0] {
        CLS_EMPTY   = 2'd0,
        CLS_INTEGER = 2'd1,
        CLS_NUMBER  = 2'd2,
        CLS_STRING  = 2'd3
    } field_class_t;

    localparam field_class_t WANTED_RST = CLS_INTEGER;

    // check_enables bit positions
    localparam int EN_COUNT = 0;
    localparam int EN_QUOTE = 1;
    localparam int EN_CTRL  = 2;
    localparam int EN_TYPE  = 3;

    // Byte codes
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DLE     = 8'h10;
    localparam logic [7:0] CH_CR      = 8'h0d;
    localparam logic [7:0] CH_PLUS    = 8'h2b;
    localparam logic [7:0] CH_MINUS   = 8'h2d;
    localparam logic [7:0] CH_COMMA   = 8'h2c;
    localparam logic [7:0] CH_PERIOD  = 8'h2e;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_SLASH   = 8'h2f;

    // One result beat
    typedef struct packed {
        logic [31:0] row_num;
        logic [15:0] fields_in_row;
        logic        is_header;
        logic        count_mismatch;
        logic        bad_quote_found;
        logic        control_byte_found;
        logic        type_match_found;
        logic        any_flag;
    } crv_result_t;

endpackage

FILE: rtl/crv_num_chk.sv
// crv_num_chk: running numeric checker for one reading of a CSV field.
// Tracks sign slot, decimal marks and failure; reports the field class so far.
// Depends on crv_pkg.
module crv_num_chk (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       clear,
    input  logic                       feed,
    input  logic [7:0]                 data,
    output crv_pkg::field_class_t      cls
);
    import crv_pkg::*;

    logic [1:0] marks_reg, marks_next;
    logic       failed_reg, failed_next;
    logic       sign_open_reg, sign_open_next;

    logic       is_sign;
    logic       is_mark;
    logic [1:0] marks_inc;

    // Per-byte update
    always_comb
    begin
        is_sign   = (data == CH_PLUS) || (data == CH_MINUS);
        is_mark   = (data == CH_COMMA) || (data == CH_PERIOD);
        marks_inc = (is_mark && (marks_reg < 2'd2)) ? marks_reg + 2'd1 : marks_reg;

        marks_next     = marks_reg;
        failed_next    = failed_reg;
        sign_open_next = sign_open_reg;
        if (clear)
        begin
            marks_next     = 2'd0;
            failed_next    = 1'b0;
            sign_open_next = 1'b1;
        end
        else if (feed)
        begin
            sign_open_next = 1'b0;
            // a leading sign is consumed and nothing else happens
            if (!(sign_open_reg && is_sign))
            begin
                marks_next  = marks_inc;
                failed_next = failed_reg || (data > CH_NINE) || (data < CH_COMMA) ||
                              (marks_inc > 2'd1) || (data == CH_MINUS) ||
                              (data == CH_SLASH);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marks_reg     <= 2'd0;
            failed_reg    <= 1'b0;
            sign_open_reg <= 1'b1;
        end
        else
        begin
            marks_reg     <= marks_next;
            failed_reg    <= failed_next;
            sign_open_reg <= sign_open_next;
        end
    end

    // Class of a non-empty field read this way
    assign cls = failed_reg ? CLS_STRING : ((marks_reg == 2'd1) ? CLS_NUMBER : CLS_INTEGER);

endmodule

FILE: rtl/crv_out_skid.sv
// crv_out_skid: two-entry output buffer (output register plus skid register).
// Lets the parser take a byte while a finished row waits downstream.
// Depends on crv_pkg.
module crv_out_skid (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  crv_pkg::crv_result_t  push_data,
    output logic                  full,
    output logic                  out_valid,
    input  logic                  out_stall,
    output crv_pkg::crv_result_t  out_data
);
    import crv_pkg::*;

    logic        out_valid_reg;
    logic        skid_valid_reg;
    crv_result_t out_data_reg;
    crv_result_t skid_data_reg;
    logic        out_free;

    assign out_free = !out_valid_reg || !out_stall;

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            // skid drains first; no push can arrive while it is full
            out_valid_reg  <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : push_data;
        end
        else if (push)
        begin
            skid_data_reg <= push_data;
        end
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: rtl/csv_row_validator.sv
// csv_row_validator: CSV byte parser that emits one checked result per row.
// Depends on crv_pkg, crv_num_chk and crv_out_skid.
//
// The block takes one CSV byte per clock and updates its row and field state in
// the same cycle; the byte (newline or end marker) that finishes a row registers its
// result into the output register, or into the skid register while the output is
// stalled. The output side is a register plus a skid register, so input bytes keep
// flowing while one result waits; in_stall rises only when both hold a row, which
// takes a second row finishing while the first is stalled downstream. Sustained
// rate: one byte per clock while in_stall is low. No clearing pass after reset.
module csv_row_validator #(
    parameter int FIELD_COUNT_BITS = 16,
    parameter int ROW_COUNT_BITS   = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration
    input  logic                               cfg_write,
    input  logic [crv_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [crv_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    // byte input
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [7:0]                         byte_value,
    input  logic                               end_of_input,
    // row result
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [31:0]                        row_num,
    output logic [15:0]                        fields_in_row,
    output logic                               is_header,
    output logic                               count_mismatch,
    output logic                               bad_quote_found,
    output logic                               control_byte_found,
    output logic                               type_match_found,
    output logic                               any_flag
);
    import crv_pkg::*;

    localparam int CMP_BITS = (FIELD_COUNT_BITS > 16) ? FIELD_COUNT_BITS : 16;
    localparam int FW_BITS  = (FIELD_COUNT_BITS > 16) ? FIELD_COUNT_BITS : 16;
    localparam int RW_BITS  = (ROW_COUNT_BITS > 32) ? ROW_COUNT_BITS : 32;

    // Configuration registers
    logic [7:0]   separator_reg;
    logic [7:0]   quote_reg;
    logic [7:0]   newline_reg;
    logic [3:0]   check_en_reg;
    logic [15:0]  type_index_reg;
    field_class_t wanted_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            separator_reg  <= SEPARATOR_RST;
            quote_reg      <= QUOTE_RST;
            newline_reg    <= NEWLINE_RST;
            check_en_reg   <= CHECK_EN_RST;
            type_index_reg <= TYPE_INDEX_RST;
            wanted_reg     <= WANTED_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_SEPARATOR:  separator_reg  <= cfg_data[7:0];
                CFG_QUOTE:      quote_reg      <= cfg_data[7:0];
                CFG_NEWLINE:    newline_reg    <= cfg_data[7:0];
                CFG_CHECK_EN:   check_en_reg   <= cfg_data[3:0];
                CFG_TYPE_INDEX: type_index_reg <= cfg_data[15:0];
                CFG_WANTED:     wanted_reg     <= field_class_t'(cfg_data[1:0]);
                default:        ;
            endcase
        end
    end

    // Parse state
    logic                        in_quotes_reg, in_quotes_next;
    logic [ROW_COUNT_BITS-1:0]   row_counter_reg, row_counter_next;
    logic [FIELD_COUNT_BITS-1:0] head_fields_reg, head_fields_next;
    logic [FIELD_COUNT_BITS-1:0] fld_cnt_reg, fld_cnt_next;
    logic                        field_over_reg, field_over_next;
    logic                        row_has_bytes_reg, row_has_bytes_next;
    logic                        field_has_bytes_reg, field_has_bytes_next;
    logic                        field_multi_reg, field_multi_next;
    logic                        first_was_quote_reg, first_was_quote_next;
    logic [7:0]                  held_byte_reg, held_byte_next;
    logic                        quote_run_odd_reg, quote_run_odd_next;
    logic                        flag_quote_reg, flag_quote_next;
    logic                        flag_ctrl_reg, flag_ctrl_next;
    logic                        flag_type_reg, flag_type_next;

    logic                        in_fire;
    logic                        is_quote, inq_toggled, ends_field, ends_row, ctrl_byte;
    logic                        do_end_field, do_emit, do_content, do_restart, field_clr;
    logic                        type_hit;
    field_class_t                plain_cls, stripped_cls, field_cls;
    logic [FIELD_COUNT_BITS-1:0] field_inc, field_after;
    logic [ROW_COUNT_BITS-1:0]   row_inc;
    logic                        hdr, mismatch;
    logic [RW_BITS-1:0]          row_wide;
    logic [FW_BITS-1:0]          field_wide;
    crv_result_t                 result;
    logic                        skid_full;

    assign in_fire  = in_valid && !in_stall;
    assign in_stall = skid_full;

    // Byte decode
    always_comb
    begin
        is_quote    = (byte_value == quote_reg);
        inq_toggled = in_quotes_reg ^ is_quote;
        ends_field  = !inq_toggled &&
                      ((byte_value == separator_reg) || (byte_value == newline_reg));
        ends_row    = ends_field && (byte_value == newline_reg);
        ctrl_byte   = (byte_value < CH_SPACE) && (byte_value != CH_DLE) &&
                      (byte_value != CH_CR);

        do_restart   = in_fire && end_of_input;
        do_end_field = in_fire && (end_of_input ? (row_has_bytes_reg && field_has_bytes_reg)
                                                : ends_field);
        do_emit      = in_fire && (end_of_input ? row_has_bytes_reg : ends_row);
        do_content   = in_fire && !end_of_input && !ends_field;
        field_clr    = do_restart || do_end_field;
    end

    // Numeric checkers: as written, and with surrounding quotes dropped
    crv_num_chk u_plain_chk (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (field_clr),
        .feed  (do_content),
        .data  (byte_value),
        .cls   (plain_cls)
    );

    crv_num_chk u_stripped_chk (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (field_clr),
        .feed  (do_content && field_has_bytes_reg && field_multi_reg),
        .data  (held_byte_reg),
        .cls   (stripped_cls)
    );

    // Field end: type check and saturating field count
    always_comb
    begin
        if (!field_has_bytes_reg)
            field_cls = CLS_EMPTY;
        else if (first_was_quote_reg && (held_byte_reg == quote_reg))
            field_cls = stripped_cls;
        else
            field_cls = plain_cls;

        type_hit    = do_end_field && !field_over_reg &&
                      (CMP_BITS'(fld_cnt_reg) == CMP_BITS'(type_index_reg)) &&
                      (field_cls == wanted_reg);
        field_inc   = (&fld_cnt_reg) ? fld_cnt_reg
                                     : fld_cnt_reg + FIELD_COUNT_BITS'(1);
        field_after = do_end_field ? field_inc : fld_cnt_reg;
    end

    // Row end: result beat
    always_comb
    begin
        row_inc  = (&row_counter_reg) ? row_counter_reg
                                      : row_counter_reg + ROW_COUNT_BITS'(1);
        hdr      = (row_inc == ROW_COUNT_BITS'(1));
        mismatch = !hdr && (field_after != head_fields_reg);
        row_wide   = RW_BITS'(row_inc);
        field_wide = FW_BITS'(field_after);

        result.row_num            = (row_wide > RW_BITS'(32'hffff_ffff)) ? 32'hffff_ffff
                                                                         : row_wide[31:0];
        result.fields_in_row      = (field_wide > FW_BITS'(16'hffff)) ? 16'hffff
                                                                      : field_wide[15:0];
        result.is_header          = hdr;
        result.count_mismatch     = mismatch;
        result.bad_quote_found    = flag_quote_reg;
        result.control_byte_found = flag_ctrl_reg;
        result.type_match_found   = flag_type_reg || type_hit;
        result.any_flag           = !hdr &&
                                    ((check_en_reg[EN_COUNT] && mismatch) ||
                                     (check_en_reg[EN_QUOTE] && flag_quote_reg) ||
                                     (check_en_reg[EN_CTRL] && flag_ctrl_reg) ||
                                     (check_en_reg[EN_TYPE] && (flag_type_reg || type_hit)));
    end

    // Next state
    always_comb
    begin
        in_quotes_next       = in_quotes_reg;
        row_counter_next     = row_counter_reg;
        head_fields_next     = head_fields_reg;
        fld_cnt_next         = fld_cnt_reg;
        field_over_next      = field_over_reg;
        row_has_bytes_next   = row_has_bytes_reg;
        field_has_bytes_next = field_has_bytes_reg;
        field_multi_next     = field_multi_reg;
        first_was_quote_next = first_was_quote_reg;
        held_byte_next       = held_byte_reg;
        quote_run_odd_next   = quote_run_odd_reg;
        flag_quote_next      = flag_quote_reg;
        flag_ctrl_next       = flag_ctrl_reg;
        flag_type_next       = flag_type_reg;

        // quoted state and row counters
        if (do_restart)
        begin
            in_quotes_next   = 1'b0;
            row_counter_next = '0;
            head_fields_next = '0;
        end
        else
        begin
            if (in_fire)
                in_quotes_next = inq_toggled;
            if (do_emit)
            begin
                row_counter_next = row_inc;
                if (hdr)
                    head_fields_next = field_after;
            end
        end

        // row-level state
        if (do_restart || do_emit)
        begin
            fld_cnt_next       = '0;
            field_over_next    = 1'b0;
            row_has_bytes_next = 1'b0;
            flag_quote_next    = 1'b0;
            flag_ctrl_next     = 1'b0;
            flag_type_next     = 1'b0;
        end
        else
        begin
            if (in_fire)
                row_has_bytes_next = 1'b1;
            if (do_end_field)
            begin
                fld_cnt_next = field_inc;
                if (&fld_cnt_reg)
                    field_over_next = 1'b1;
            end
            flag_type_next  = flag_type_reg || type_hit;
            flag_ctrl_next  = flag_ctrl_reg || (do_content && ctrl_byte);
            // an odd quote run followed by a non-quote content byte
            flag_quote_next = flag_quote_reg ||
                              (do_content && !is_quote && quote_run_odd_reg);
        end

        // field-level state
        if (field_clr)
        begin
            field_has_bytes_next = 1'b0;
            field_multi_next     = 1'b0;
            first_was_quote_next = 1'b0;
            held_byte_next       = 8'h00;
            quote_run_odd_next   = 1'b0;
        end
        else if (do_content)
        begin
            if (is_quote)
                quote_run_odd_next = quote_run_odd_reg ^ field_has_bytes_reg;
            else
                quote_run_odd_next = 1'b0;
            if (!field_has_bytes_reg)
                first_was_quote_next = is_quote;
            else
                field_multi_next = 1'b1;
            held_byte_next       = byte_value;
            field_has_bytes_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_quotes_reg       <= 1'b0;
            row_counter_reg     <= '0;
            head_fields_reg     <= '0;
            fld_cnt_reg         <= '0;
            field_over_reg      <= 1'b0;
            row_has_bytes_reg   <= 1'b0;
            field_has_bytes_reg <= 1'b0;
            field_multi_reg     <= 1'b0;
            first_was_quote_reg <= 1'b0;
            held_byte_reg       <= 8'h00;
            quote_run_odd_reg   <= 1'b0;
            flag_quote_reg      <= 1'b0;
            flag_ctrl_reg       <= 1'b0;
            flag_type_reg       <= 1'b0;
        end
        else
        begin
            in_quotes_reg       <= in_quotes_next;
            row_counter_reg     <= row_counter_next;
            head_fields_reg     <= head_fields_next;
            fld_cnt_reg         <= fld_cnt_next;
            field_over_reg      <= field_over_next;
            row_has_bytes_reg   <= row_has_bytes_next;
            field_has_bytes_reg <= field_has_bytes_next;
            field_multi_reg     <= field_multi_next;
            first_was_quote_reg <= first_was_quote_next;
            held_byte_reg       <= held_byte_next;
            quote_run_odd_reg   <= quote_run_odd_next;
            flag_quote_reg      <= flag_quote_next;
            flag_ctrl_reg       <= flag_ctrl_next;
            flag_type_reg       <= flag_type_next;
        end
    end

    // Output buffer
    crv_result_t out_data;

    crv_out_skid u_out_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (do_emit),
        .push_data (result),
        .full      (skid_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign row_num            = out_data.row_num;
    assign fields_in_row      = out_data.fields_in_row;
    assign is_header          = out_data.is_header;
    assign count_mismatch     = out_data.count_mismatch;
    assign bad_quote_found    = out_data.bad_quote_found;
    assign control_byte_found = out_data.control_byte_found;
    assign type_match_found   = out_data.type_match_found;
    assign any_flag           = out_data.any_flag;

    // Checks
    a_stall_needs_beat: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no result beat held");

    a_header_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_header) |-> (!any_flag && !count_mismatch && row_num == 32'd1))
        else $error("header beat carries flags or a row number other than one");

    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && end_of_input) |=>
            (!in_quotes_reg && row_counter_reg == '0 && !row_has_bytes_reg))
        else $error("end marker did not restart the parse");

    a_over_at_max: assert property (@(posedge clk) disable iff (!rst_n)
        field_over_reg |-> (&fld_cnt_reg))
        else $error("field overflow without a saturated field count");

endmodule

FILE: verif/csv_row_validator_test.sv
// csv_row_validator_test: self-checking testbench for the CSV row validator.
// Byte beats go in, predicted row results are compared field by field.
// Depends on crv_pkg and csv_row_validator.
module csv_row_validator_test;

    import crv_pkg::*;

    localparam int LONG_HOLD      = 160;
    localparam int SETTLE         = 3;
    localparam int PHASE_BEATS    = 62;
    localparam int PHASES         = 9;
    localparam int QUIET_PHASE    = 8;
    localparam int HOLD_PHASE     = 3;

    localparam logic [7:0] ASCII_ZERO    = 8'h30;
    localparam logic [7:0] ASCII_LOWER_A = 8'h61;
    localparam logic [7:0] ASCII_PIPE    = 8'h7c;
    localparam logic [7:0] ASCII_SEMI    = 8'h3b;
    localparam logic [7:0] ASCII_APOS    = 8'h27;

    // row_flags bit positions
    localparam int FLAG_QUOTE = 0;
    localparam int FLAG_CTRL  = 1;
    localparam int FLAG_TYPE  = 2;

    typedef struct packed {
        logic [7:0] value;
        logic       flush;
    } csv_beat_t;

    typedef struct packed {
        logic [1:0] marks;
        logic       failed;
        logic       sign_open;
    } num_scan_t;

    localparam num_scan_t SCAN_IDLE = '{marks: 2'd0, failed: 1'b0, sign_open: 1'b1};

    logic                      clk          = 1'b0;
    logic                      rst_n        = 1'b0;
    logic                      cfg_write    = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index    = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data     = '0;
    logic                      in_valid     = 1'b0;
    logic                      in_stall;
    logic [7:0]                byte_value   = 8'h00;
    logic                      end_of_input = 1'b0;
    logic                      out_valid;
    logic                      out_stall    = 1'b0;
    logic [31:0]               row_num;
    logic [15:0]               fields_in_row;
    logic                      is_header;
    logic                      count_mismatch;
    logic                      bad_quote_found;
    logic                      control_byte_found;
    logic                      type_match_found;
    logic                      any_flag;

    csv_row_validator DUT (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_write          (cfg_write),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .byte_value         (byte_value),
        .end_of_input       (end_of_input),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .row_num            (row_num),
        .fields_in_row      (fields_in_row),
        .is_header          (is_header),
        .count_mismatch     (count_mismatch),
        .bad_quote_found    (bad_quote_found),
        .control_byte_found (control_byte_found),
        .type_match_found   (type_match_found),
        .any_flag           (any_flag)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Register copies
    logic [7:0]   sep_code     = SEPARATOR_RST;
    logic [7:0]   quote_code   = QUOTE_RST;
    logic [7:0]   newline_code = NEWLINE_RST;
    logic [3:0]   check_en     = CHECK_EN_RST;
    logic [15:0]  type_index   = TYPE_INDEX_RST;
    field_class_t wanted_class = WANTED_RST;

    // Parser state
    logic        in_quotes       = 1'b0;
    logic        row_has_bytes   = 1'b0;
    logic        field_has_bytes = 1'b0;
    logic        first_was_quote = 1'b0;
    logic        quote_run_odd   = 1'b0;
    logic        field_multi     = 1'b0;
    logic        field_over      = 1'b0;
    logic [31:0] row_count       = '0;
    logic [15:0] head_fields     = '0;
    logic [15:0] fld_tally       = '0;
    logic [7:0]  held_byte       = 8'h00;
    logic [2:0]  row_flags       = '0;
    num_scan_t   plain_scan      = SCAN_IDLE;
    num_scan_t   stripped_scan   = SCAN_IDLE;

    crv_result_t rows_due[$];
    csv_beat_t   beats_pending[$];
    int          items_queued   = 0;
    int          mismatch_count = 0;
    logic        quiet_phase    = 1'b0;
    int          hold_requests  = 0;

    // Numeric reading: optional sign, digits, at most one comma or period
    function automatic num_scan_t scan_numeric(num_scan_t s, logic [7:0] c);
        if (s.sign_open)
        begin
            s.sign_open = 1'b0;
            if (c == CH_PLUS || c == CH_MINUS)
                return s;
        end
        if ((c == CH_COMMA || c == CH_PERIOD) && s.marks < 2'd2)
            s.marks = s.marks + 2'd1;
        if (c > CH_NINE || c < CH_COMMA || s.marks > 2'd1 || c == CH_MINUS || c == CH_SLASH)
            s.failed = 1'b1;
        return s;
    endfunction

    function automatic void clear_field();
        field_has_bytes = 1'b0;
        field_multi     = 1'b0;
        first_was_quote = 1'b0;
        quote_run_odd   = 1'b0;
        held_byte       = 8'h00;
        plain_scan      = SCAN_IDLE;
        stripped_scan   = SCAN_IDLE;
    endfunction

    function automatic void clear_row();
        clear_field();
        fld_tally     = '0;
        field_over    = 1'b0;
        row_flags     = '0;
        row_has_bytes = 1'b0;
    endfunction

    function automatic void take_content(logic [7:0] c);
        if (c < CH_SPACE && c != CH_DLE && c != CH_CR)
            row_flags[FLAG_CTRL] = 1'b1;
        if (c == quote_code)
        begin
            if (field_has_bytes)
                quote_run_odd = !quote_run_odd;
        end
        else
        begin
            if (quote_run_odd)
                row_flags[FLAG_QUOTE] = 1'b1;
            quote_run_odd = 1'b0;
        end
        // stripped reading lags one byte so a closing quote is never fed
        if (!field_has_bytes)
            first_was_quote = (c == quote_code);
        else
        begin
            if (field_multi)
                stripped_scan = scan_numeric(stripped_scan, held_byte);
            field_multi = 1'b1;
        end
        plain_scan      = scan_numeric(plain_scan, c);
        held_byte       = c;
        field_has_bytes = 1'b1;
    endfunction

    function automatic void close_field();
        num_scan_t    pick;
        field_class_t cls;
        if (!field_over && fld_tally == type_index)
        begin
            if (!field_has_bytes)
                cls = CLS_EMPTY;
            else
            begin
                pick = (first_was_quote && held_byte == quote_code) ? stripped_scan : plain_scan;
                if (pick.failed)
                    cls = CLS_STRING;
                else if (pick.marks == 2'd1)
                    cls = CLS_NUMBER;
                else
                    cls = CLS_INTEGER;
            end
            if (cls == wanted_class)
                row_flags[FLAG_TYPE] = 1'b1;
        end
        if (fld_tally != 16'hffff)
            fld_tally = fld_tally + 16'd1;
        else
            field_over = 1'b1;
        clear_field();
    endfunction

    function automatic void finish_row();
        crv_result_t done;
        logic        hdr;
        logic        mis;
        if (row_count != 32'hffff_ffff)
            row_count = row_count + 32'd1;
        hdr = (row_count == 32'd1);
        if (hdr)
            head_fields = fld_tally;
        mis = !hdr && fld_tally != head_fields;
        done.row_num            = row_count;
        done.fields_in_row      = fld_tally;
        done.is_header          = hdr;
        done.count_mismatch     = mis;
        done.bad_quote_found    = row_flags[FLAG_QUOTE];
        done.control_byte_found = row_flags[FLAG_CTRL];
        done.type_match_found   = row_flags[FLAG_TYPE];
        done.any_flag = !hdr && ((check_en[EN_COUNT] && mis) ||
                                 (check_en[EN_QUOTE] && row_flags[FLAG_QUOTE]) ||
                                 (check_en[EN_CTRL] && row_flags[FLAG_CTRL]) ||
                                 (check_en[EN_TYPE] && row_flags[FLAG_TYPE]));
        rows_due.insert(rows_due.size(), done);
        clear_row();
    endfunction

    // One accepted beat through the parser
    function automatic void take_beat(logic [7:0] c, logic flush);
        if (flush)
        begin
            if (row_has_bytes)
            begin
                if (field_has_bytes)
                    close_field();
                finish_row();
            end
            in_quotes   = 1'b0;
            row_count   = '0;
            head_fields = '0;
            clear_row();
        end
        else
        begin
            if (c == quote_code)
                in_quotes = !in_quotes;
            row_has_bytes = 1'b1;
            if (!in_quotes && (c == sep_code || c == newline_code))
            begin
                close_field();
                if (c == newline_code)
                    finish_row();
            end
            else
                take_content(c);
        end
    endfunction

    task automatic note_mismatch(input string msg);
        mismatch_count++;
        $display("%0t: mismatch: %s", $time, msg);
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want, input logic [31:0] row);
        if (got !== want)
            note_mismatch($sformatf("row %0d %s got %0h want %0h", row, name, got, want));
    endtask

    // Sender: pops pending beats, idles in bursts
    csv_beat_t next_beat;
    int        send_gap       = 0;
    int        send_mode_left = 0;
    logic      send_choppy    = 1'b0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (send_mode_left == 0)
            begin
                send_choppy    = ($urandom_range(0, 2) != 0);
                send_mode_left = $urandom_range(20, 100);
            end
            else
                send_mode_left--;
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (!quiet_phase && send_choppy && $urandom_range(0, 7) == 0)
                begin
                    send_gap = $urandom_range(0, 13);
                    in_valid <= 1'b0;
                end
                else if (beats_pending.size() != 0)
                begin
                    next_beat = beats_pending.pop_front();
                    byte_value   <= next_beat.value;
                    end_of_input <= next_beat.flush;
                    in_valid     <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver stall: random bursts plus requested long hold-offs
    int   hold_left      = 0;
    int   holds_served   = 0;
    int   stall_gap      = 0;
    int   recv_mode_left = 0;
    logic recv_choppy    = 1'b0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (recv_mode_left == 0)
            begin
                recv_choppy    = ($urandom_range(0, 2) != 0);
                recv_mode_left = $urandom_range(20, 100);
            end
            else
                recv_mode_left--;
            if (holds_served != hold_requests)
            begin
                hold_left = LONG_HOLD;
                holds_served++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (stall_gap > 0)
            begin
                stall_gap--;
                out_stall <= 1'b1;
            end
            else if (!quiet_phase && recv_choppy && $urandom_range(0, 5) == 0)
            begin
                stall_gap = $urandom_range(0, 13);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Monitor: check the result beat first, then predict from the byte beat
    crv_result_t want_row;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (rows_due.size() == 0)
                    note_mismatch($sformatf("unexpected result row %0d", row_num));
                else
                begin
                    want_row = rows_due.pop_front();
                    compare_field("row_num", row_num, want_row.row_num,
                                  want_row.row_num);
                    compare_field("fields_in_row", 32'(fields_in_row),
                                  32'(want_row.fields_in_row), want_row.row_num);
                    compare_field("is_header", 32'(is_header), 32'(want_row.is_header),
                                  want_row.row_num);
                    compare_field("count_mismatch", 32'(count_mismatch),
                                  32'(want_row.count_mismatch), want_row.row_num);
                    compare_field("bad_quote_found", 32'(bad_quote_found),
                                  32'(want_row.bad_quote_found), want_row.row_num);
                    compare_field("control_byte_found", 32'(control_byte_found),
                                  32'(want_row.control_byte_found), want_row.row_num);
                    compare_field("type_match_found", 32'(type_match_found),
                                  32'(want_row.type_match_found), want_row.row_num);
                    compare_field("any_flag", 32'(any_flag), 32'(want_row.any_flag),
                                  want_row.row_num);
                end
            end
            if (in_valid && !in_stall)
                take_beat(byte_value, end_of_input);
        end
    end

    // Stimulus helpers
    task automatic push_byte(input logic [7:0] v);
        beats_pending.insert(beats_pending.size(), {v, 1'b0});
        items_queued++;
    endtask

    task automatic push_flush();
        beats_pending.insert(beats_pending.size(), {8'($urandom_range(0, 255)), 1'b1});
        items_queued++;
    endtask

    function automatic logic [7:0] rand_digit();
        return ASCII_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rand_letter();
        return ASCII_LOWER_A + 8'($urandom_range(0, 25));
    endfunction

    task automatic push_digits();
        int n;
        n = $urandom_range(1, 4);
        repeat (n) push_byte(rand_digit());
    endtask

    task automatic push_sign();
        case ($urandom_range(0, 3))
            0: push_byte(CH_PLUS);
            1: push_byte(CH_MINUS);
            default: ;
        endcase
    endtask

    task automatic add_field();
        int n;
        case ($urandom_range(0, 9))
            0: ;
            1:
            begin
                push_sign();
                push_digits();
            end
            2:
            begin
                push_sign();
                push_digits();
                push_byte($urandom_range(0, 3) == 0 ? CH_COMMA : CH_PERIOD);
                push_digits();
            end
            3:
            begin
                push_byte(quote_code);
                push_sign();
                push_digits();
                if ($urandom_range(0, 1) == 1)
                begin
                    push_byte(CH_PERIOD);
                    push_digits();
                end
                push_byte(quote_code);
            end
            4:
            begin
                // quoted text with an escaped quote pair
                push_byte(quote_code);
                push_byte(rand_letter());
                push_byte(quote_code);
                push_byte(quote_code);
                push_byte(rand_letter());
                push_byte(quote_code);
            end
            5:
            begin
                n = $urandom_range(1, 4);
                repeat (n) push_byte(rand_letter());
            end
            6:
            begin
                // lone interior quote followed by text
                push_byte(rand_letter());
                push_byte(quote_code);
                push_byte(rand_letter());
                push_byte(quote_code);
            end
            7:
            begin
                push_byte(rand_letter());
                push_byte(8'($urandom_range(0, 31)));
            end
            8:
            begin
                n = $urandom_range(1, 3);
                repeat (n) push_byte(8'($urandom_range(0, 255)));
            end
            default:
            begin
                // malformed number
                push_byte(rand_digit());
                push_byte($urandom_range(0, 1) == 1 ? CH_PERIOD : CH_MINUS);
                push_byte(rand_digit());
                push_byte(CH_PERIOD);
                push_byte(rand_digit());
            end
        endcase
    endtask

    task automatic add_row(input int n_fields);
        for (int i = 0; i < n_fields; i++)
        begin
            add_field();
            if (i < n_fields - 1)
                push_byte(sep_code);
        end
        case ($urandom_range(0, 24))
            0: push_flush();
            1:
            begin
                push_byte(sep_code);
                push_flush();
            end
            default: push_byte(newline_code);
        endcase
    endtask

    // Register writes, one per clock; copies follow immediately
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [15:0] value);
        case (idx)
            CFG_SEPARATOR:  sep_code     = value[7:0];
            CFG_QUOTE:      quote_code   = value[7:0];
            CFG_NEWLINE:    newline_code = value[7:0];
            CFG_CHECK_EN:   check_en     = value[3:0];
            CFG_TYPE_INDEX: type_index   = value;
            CFG_WANTED:     wanted_class = field_class_t'(value[1:0]);
            default: ;
        endcase
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
    endtask

    task automatic end_writes();
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic configure(input logic [7:0] sep, input logic [7:0] quo,
                             input logic [7:0] nl, input logic [3:0] en,
                             input logic [15:0] tfi, input field_class_t want);
        write_reg(CFG_SEPARATOR, {8'h00, sep});
        write_reg(CFG_QUOTE, {8'h00, quo});
        write_reg(CFG_NEWLINE, {8'h00, nl});
        write_reg(CFG_CHECK_EN, {12'h000, en});
        write_reg(CFG_TYPE_INDEX, tfi);
        write_reg(CFG_WANTED, {14'h0000, want});
        end_writes();
    endtask

    // Idle once nothing is queued, in flight or expected
    task automatic wait_drained();
        while (beats_pending.size() != 0 || in_valid || rows_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    initial
    begin
        int p;
        int hdr_n;
        int start;
        int pick;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: quoted integer header, signed integer, extremes with bad quote
        push_byte(QUOTE_RST);
        push_byte(ASCII_ZERO + 8'd4);
        push_byte(QUOTE_RST);
        push_byte(SEPARATOR_RST);
        push_byte(ASCII_LOWER_A);
        push_byte(QUOTE_RST);
        push_byte(QUOTE_RST);
        push_byte(ASCII_LOWER_A);
        push_byte(NEWLINE_RST);
        push_byte(CH_MINUS);
        push_byte(ASCII_ZERO + 8'd7);
        push_byte(NEWLINE_RST);
        push_byte(8'hff);
        push_byte(8'h00);
        push_byte(SEPARATOR_RST);
        push_byte(ASCII_LOWER_A);
        push_byte(QUOTE_RST);
        push_byte(ASCII_LOWER_A);
        push_byte(QUOTE_RST);
        push_byte(NEWLINE_RST);
        // flush with nothing pending, then flush right after a separator
        push_flush();
        push_byte(ASCII_ZERO + 8'd1);
        push_byte(SEPARATOR_RST);
        push_flush();
        // exempt control bytes only
        push_byte(CH_DLE);
        push_byte(CH_CR);
        push_byte(NEWLINE_RST);

        // Random phases, one register setting each
        for (p = 0; p < PHASES; p++)
        begin
            wait_drained();
            case (p)
                0: configure(SEPARATOR_RST, QUOTE_RST, NEWLINE_RST, 4'h0, 16'd0, CLS_EMPTY);
                1: configure(8'h00, 8'hff, NEWLINE_RST, 4'hf, 16'd1, CLS_STRING);
                2: configure(ASCII_SEMI, QUOTE_RST, ASCII_SEMI, 4'($urandom_range(0, 15)),
                             16'd2, CLS_NUMBER);
                3: configure(SEPARATOR_RST, SEPARATOR_RST, NEWLINE_RST, 4'hf, 16'd0,
                             CLS_INTEGER);
                4: configure(ASCII_PIPE, ASCII_APOS, CH_CR, 4'($urandom_range(0, 15)),
                             16'($urandom_range(0, 3)), field_class_t'($urandom_range(0, 3)));
                5: configure(SEPARATOR_RST, QUOTE_RST, NEWLINE_RST, 4'($urandom_range(0, 15)),
                             16'hffff, field_class_t'($urandom_range(0, 3)));
                6: configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                             16'($urandom_range(0, 5)), field_class_t'($urandom_range(0, 3)));
                7: configure(SEPARATOR_RST, QUOTE_RST, NEWLINE_RST, 4'hf,
                             16'($urandom_range(0, 3)), CLS_INTEGER);
                default: configure(SEPARATOR_RST, QUOTE_RST, NEWLINE_RST,
                                   4'($urandom_range(0, 15)), 16'd0, CLS_INTEGER);
            endcase
            @(negedge clk);
            if (p == HOLD_PHASE)
                hold_requests++;
            if (p == QUIET_PHASE)
                quiet_phase = 1'b1;
            hdr_n = $urandom_range(1, 4);
            start = items_queued;
            while (items_queued - start < PHASE_BEATS)
            begin
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    push_flush();
                else if (pick == 1)
                    push_byte(8'($urandom_range(0, 255)));
                else if (pick < 5)
                    add_row($urandom_range(1, 6));
                else
                    add_row(hdr_n);
            end
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("csv_row_validator_test: PASS");
        else
            $display("csv_row_validator_test: FAIL");
        $finish;
    end

    // Watchdog
    initial
    begin
        #10_000_000;
        $display("csv_row_validator_test: FAIL");
        $finish;
    end

endmodule
